// ===== rtl/qau_pkg.sv =====
// Quaternion arithmetic unit: shared operation codes and types.
// No dependencies; imported by every module of the unit.
package qau_pkg;

   localparam int NCOMP = 4;

   typedef logic [1:0] op_type;

   localparam op_type OP_CONJ = 2'd0;
   localparam op_type OP_NORM = 2'd1;
   localparam op_type OP_MUL  = 2'd2;
   localparam op_type OP_ROT  = 2'd3;

endpackage

// ===== rtl/qau_front.sv =====
// Front pipeline: products, sums, rotate second pass, rounding and saturation.
// Six register stages. Depends on qau_pkg.
module qau_front #(
   parameter int WORD_BITS = 16,
   parameter int FRAC_BITS = 14
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  qau_pkg::op_type                  in_op,
   input  logic signed [WORD_BITS-1:0]      in_a [4],
   input  logic signed [WORD_BITS-1:0]      in_b [4],
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [4*WORD_BITS+7:0]           out_side,
   output logic [2*WORD_BITS:0]             out_s,
   output logic signed [2*WORD_BITS-1:0]    out_sq [4]
);
   import qau_pkg::*;

   localparam int W   = WORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int PW  = 2 * W;
   localparam int MW  = 2 * W + 2;
   localparam int RPW = 3 * W + 2;
   localparam int RSW = 3 * W + 4;
   localparam int SW  = 2 * W + 1;
   localparam int GW  = RSW + 1;
   localparam int NS  = 6;
   localparam logic signed [GW-1:0] WMAX   = (GW'(1) <<< (W - 1)) - GW'(1);
   localparam logic signed [GW-1:0] WMIN   = -WMAX - GW'(1);
   localparam logic signed [GW-1:0] M_HALF = GW'(1) <<< (F - 1);
   localparam logic signed [GW-1:0] R_HALF = GW'(1) <<< (2 * F - 1);

   function automatic logic [W:0] sat_word(input logic signed [GW-1:0] v);
      logic [W:0] res;
      if (v > WMAX) begin
         res = {1'b1, WMAX[W-1:0]};
      end else if (v < WMIN) begin
         res = {1'b1, WMIN[W-1:0]};
      end else begin
         res = {1'b0, v[W-1:0]};
      end
      return res;
   endfunction

   logic [NS-1:0] v_ff;
   logic [NS:0]   rdy;

   op_type                op0_ff, op1_ff, op2_ff, op3_ff, op4_ff;
   logic signed [W-1:0]   a0_ff [NCOMP];
   logic signed [W-1:0]   b0_ff [NCOMP];
   logic signed [W-1:0]   a1_ff [NCOMP];
   logic signed [W-1:0]   a2_ff [NCOMP];
   logic signed [W-1:0]   a3_ff [NCOMP];
   logic signed [W-1:0]   a4_ff [NCOMP];
   logic signed [PW-1:0]  p_in  [NCOMP][NCOMP];
   logic signed [PW-1:0]  p1_ff [NCOMP][NCOMP];
   logic signed [PW-1:0]  sq_in  [NCOMP];
   logic signed [PW-1:0]  sq1_ff [NCOMP];
   logic signed [PW-1:0]  sq2_ff [NCOMP];
   logic signed [PW-1:0]  sq3_ff [NCOMP];
   logic signed [PW-1:0]  sq4_ff [NCOMP];
   logic signed [PW-1:0]  sq5_ff [NCOMP];
   logic signed [MW-1:0]  m_in  [NCOMP];
   logic signed [MW-1:0]  t_in  [NCOMP];
   logic signed [MW-1:0]  m2_ff [NCOMP];
   logic signed [MW-1:0]  t2_ff [NCOMP];
   logic signed [MW-1:0]  m3_ff [NCOMP];
   logic signed [MW-1:0]  m4_ff [NCOMP];
   logic [SW-1:0]         s_in;
   logic [SW-1:0]         s2_ff, s3_ff, s4_ff, s5_ff;
   logic signed [RPW-1:0] rp_in  [NCOMP][NCOMP];
   logic signed [RPW-1:0] rp3_ff [NCOMP][NCOMP];
   logic signed [RSW-1:0] q_in  [3];
   logic signed [RSW-1:0] q4_ff [3];
   logic [W:0]            res_in [NCOMP];
   logic                  zn_in;
   logic                  clip_in;
   logic [4*W+7:0]        side_in;
   logic [4*W+7:0]        side5_ff;

   assign rdy[NS] = out_ready;
   for (genvar g = 0; g < NS; g++) begin : g_rdy
      assign rdy[g] = !v_ff[g] || rdy[g+1];
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NCOMP; i++) begin
         sq_in[i] = PW'(a0_ff[i]) * PW'(a0_ff[i]);
         for (int j = 0; j < NCOMP; j++) begin
            p_in[i][j] = PW'(a0_ff[i]) * PW'(b0_ff[j]);
         end
      end
   end

   always_comb begin
      m_in[0] = MW'(p1_ff[0][0]) - MW'(p1_ff[1][1]) - MW'(p1_ff[2][2]) - MW'(p1_ff[3][3]);
      m_in[1] = MW'(p1_ff[0][1]) + MW'(p1_ff[1][0]) + MW'(p1_ff[2][3]) - MW'(p1_ff[3][2]);
      m_in[2] = MW'(p1_ff[0][2]) - MW'(p1_ff[1][3]) + MW'(p1_ff[2][0]) + MW'(p1_ff[3][1]);
      m_in[3] = MW'(p1_ff[0][3]) + MW'(p1_ff[1][2]) - MW'(p1_ff[2][1]) + MW'(p1_ff[3][0]);
      t_in[0] = MW'(p1_ff[0][1]) - MW'(p1_ff[3][2]) + MW'(p1_ff[2][3]);
      t_in[1] = MW'(p1_ff[1][2]) - MW'(p1_ff[2][1]) + MW'(p1_ff[0][3]);
      t_in[2] = MW'(p1_ff[1][1]) + MW'(p1_ff[2][2]) + MW'(p1_ff[3][3]);
      t_in[3] = MW'(p1_ff[3][1]) + MW'(p1_ff[0][2]) - MW'(p1_ff[1][3]);
      s_in = SW'(sq1_ff[0]) + SW'(sq1_ff[1]) + SW'(sq1_ff[2]) + SW'(sq1_ff[3]);
   end

   always_comb begin
      for (int i = 0; i < NCOMP; i++) begin
         for (int j = 0; j < NCOMP; j++) begin
            rp_in[i][j] = RPW'(a2_ff[i]) * RPW'(t2_ff[j]);
         end
      end
   end

   always_comb begin
      q_in[0] = RSW'(rp3_ff[0][0]) + RSW'(rp3_ff[2][1]) + RSW'(rp3_ff[1][2])
              - RSW'(rp3_ff[3][3]);
      q_in[1] = RSW'(rp3_ff[0][3]) - RSW'(rp3_ff[1][1]) + RSW'(rp3_ff[2][2])
              + RSW'(rp3_ff[3][0]);
      q_in[2] = RSW'(rp3_ff[0][1]) + RSW'(rp3_ff[1][3]) - RSW'(rp3_ff[2][0])
              + RSW'(rp3_ff[3][2]);
   end

   always_comb begin
      for (int i = 0; i < NCOMP; i++) begin
         res_in[i] = '0;
      end
      zn_in = 1'b0;
      case (op4_ff)
         OP_CONJ: begin
            res_in[0] = sat_word(GW'(a4_ff[0]));
            for (int i = 1; i < NCOMP; i++) begin
               res_in[i] = sat_word(-GW'(a4_ff[i]));
            end
         end
         OP_NORM: begin
            zn_in = (s4_ff == '0);
         end
         OP_MUL: begin
            for (int i = 0; i < NCOMP; i++) begin
               res_in[i] = sat_word((GW'(m4_ff[i]) + M_HALF) >>> F);
            end
         end
         OP_ROT: begin
            for (int i = 1; i < NCOMP; i++) begin
               res_in[i] = sat_word((GW'(q4_ff[i-1]) + R_HALF) >>> (2 * F));
            end
         end
      endcase
      clip_in = res_in[0][W] | res_in[1][W] | res_in[2][W] | res_in[3][W];
      side_in = {op4_ff, a4_ff[3][W-1], a4_ff[2][W-1], a4_ff[1][W-1], a4_ff[0][W-1],
                 zn_in, clip_in, res_in[3][W-1:0], res_in[2][W-1:0], res_in[1][W-1:0],
                 res_in[0][W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         op0_ff <= in_op;
         a0_ff  <= in_a;
         b0_ff  <= in_b;
      end
      if (rdy[1]) begin
         op1_ff <= op0_ff;
         a1_ff  <= a0_ff;
         p1_ff  <= p_in;
         sq1_ff <= sq_in;
      end
      if (rdy[2]) begin
         op2_ff <= op1_ff;
         a2_ff  <= a1_ff;
         m2_ff  <= m_in;
         t2_ff  <= t_in;
         s2_ff  <= s_in;
         sq2_ff <= sq1_ff;
      end
      if (rdy[3]) begin
         op3_ff <= op2_ff;
         a3_ff  <= a2_ff;
         m3_ff  <= m2_ff;
         s3_ff  <= s2_ff;
         sq3_ff <= sq2_ff;
         rp3_ff <= rp_in;
      end
      if (rdy[4]) begin
         op4_ff <= op3_ff;
         a4_ff  <= a3_ff;
         m4_ff  <= m3_ff;
         s4_ff  <= s3_ff;
         sq4_ff <= sq3_ff;
         q4_ff  <= q_in;
      end
      if (rdy[5]) begin
         side5_ff <= side_in;
         s5_ff    <= s4_ff;
         sq5_ff   <= sq4_ff;
      end
   end

   assign out_side = side5_ff;
   assign out_s    = s5_ff;
   assign out_sq   = sq5_ff;

endmodule

// ===== rtl/qau_isqrt_stage.sv =====
// One bit of the normalize search: tries one result bit for all four components.
// One register stage. Depends on qau_pkg.
module qau_isqrt_stage #(
   parameter int WORD_BITS = 16,
   parameter int FRAC_BITS = 14,
   parameter int BIT       = 14
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         up_valid,
   output logic                                         up_ready,
   input  logic [4*WORD_BITS+7:0]                       up_side,
   input  logic [2*WORD_BITS:0]                         up_s,
   input  logic signed [2*FRAC_BITS+2*WORD_BITS+3:0]    up_tgt [4],
   input  logic signed [2*FRAC_BITS+2*WORD_BITS+3:0]    up_x [4],
   input  logic signed [2*FRAC_BITS+2*WORD_BITS+3:0]    up_y [4],
   input  logic [FRAC_BITS:0]                           up_lo [4],
   output logic                                         dn_valid,
   input  logic                                         dn_ready,
   output logic [4*WORD_BITS+7:0]                       dn_side,
   output logic [2*WORD_BITS:0]                         dn_s,
   output logic signed [2*FRAC_BITS+2*WORD_BITS+3:0]    dn_tgt [4],
   output logic signed [2*FRAC_BITS+2*WORD_BITS+3:0]    dn_x [4],
   output logic signed [2*FRAC_BITS+2*WORD_BITS+3:0]    dn_y [4],
   output logic [FRAC_BITS:0]                           dn_lo [4]
);
   import qau_pkg::*;

   localparam int F  = FRAC_BITS;
   localparam int XW = 2 * FRAC_BITS + 2 * WORD_BITS + 4;

   logic                 v_ff;
   logic signed [XW-1:0] s_ext;
   logic signed [XW-1:0] trial [NCOMP];
   logic                 take  [NCOMP];
   logic signed [XW-1:0] x_in  [NCOMP];
   logic signed [XW-1:0] y_in  [NCOMP];
   logic [F:0]           lo_in [NCOMP];
   logic [4*WORD_BITS+7:0] side_ff;
   logic [2*WORD_BITS:0]   s_ff;
   logic signed [XW-1:0]   tgt_ff [NCOMP];
   logic signed [XW-1:0]   x_ff   [NCOMP];
   logic signed [XW-1:0]   y_ff   [NCOMP];
   logic [F:0]             lo_ff  [NCOMP];

   assign up_ready = !v_ff || dn_ready;
   assign s_ext    = signed'(XW'(up_s));

   always_comb begin
      for (int i = 0; i < NCOMP; i++) begin
         trial[i] = up_x[i] + (up_y[i] <<< (BIT + 2)) + (s_ext <<< (2 * BIT + 2));
         take[i]  = !up_lo[i][F] && (trial[i] <= up_tgt[i]);
         x_in[i]  = take[i] ? trial[i] : up_x[i];
         y_in[i]  = take[i] ? up_y[i] + (s_ext <<< (BIT + 1)) : up_y[i];
         lo_in[i] = take[i] ? up_lo[i] | ((F + 1)'(1) << BIT) : up_lo[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (up_ready) begin
         v_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         side_ff <= up_side;
         s_ff    <= up_s;
         tgt_ff  <= up_tgt;
         x_ff    <= x_in;
         y_ff    <= y_in;
         lo_ff   <= lo_in;
      end
   end

   assign dn_valid = v_ff;
   assign dn_side  = side_ff;
   assign dn_s     = s_ff;
   assign dn_tgt   = tgt_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;
   assign dn_lo    = lo_ff;

endmodule

// ===== rtl/qau_out.sv =====
// Output stage: signs and saturates normalize results, selects, holds the result register.
// One register stage. Depends on qau_pkg.
module qau_out #(
   parameter int WORD_BITS = 16,
   parameter int FRAC_BITS = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         up_valid,
   output logic                         up_ready,
   input  logic [4*WORD_BITS+7:0]       up_side,
   input  logic [FRAC_BITS:0]           up_lo [4],
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [WORD_BITS-1:0]  out_r [4],
   output logic                         out_clipped,
   output logic                         out_zero_norm
);
   import qau_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int OW = (F + 2 > W + 1) ? F + 2 : W + 1;
   localparam logic signed [OW-1:0] WMAX = (OW'(1) <<< (W - 1)) - OW'(1);
   localparam logic signed [OW-1:0] WMIN = -WMAX - OW'(1);

   logic                v_ff;
   op_type              op;
   logic                zn;
   logic signed [OW-1:0] mag  [NCOMP];
   logic signed [OW-1:0] sval [NCOMP];
   logic [W-1:0]        r_in [NCOMP];
   logic [NCOMP-1:0]    cl;
   logic                clip_in;
   logic [W-1:0]        r_ff [NCOMP];
   logic                clip_ff;
   logic                zn_ff;

   assign up_ready = !v_ff || out_ready;
   assign op       = up_side[4*W+7:4*W+6];
   assign zn       = up_side[4*W+1];

   always_comb begin
      for (int i = 0; i < NCOMP; i++) begin
         mag[i]  = signed'(OW'(up_lo[i]));
         sval[i] = up_side[4*W+2+i] ? -mag[i] : mag[i];
         r_in[i] = up_side[i*W +: W];
         cl[i]   = 1'b0;
         if (op == OP_NORM && !zn) begin
            if (sval[i] > WMAX) begin
               r_in[i] = WMAX[W-1:0];
               cl[i]   = 1'b1;
            end else if (sval[i] < WMIN) begin
               r_in[i] = WMIN[W-1:0];
               cl[i]   = 1'b1;
            end else begin
               r_in[i] = sval[i][W-1:0];
            end
         end
      end
      clip_in = up_side[4*W] | (|cl);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (up_ready) begin
         v_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         r_ff    <= r_in;
         clip_ff <= clip_in;
         zn_ff   <= zn;
      end
   end

   assign out_valid     = v_ff;
   assign out_clipped   = clip_ff;
   assign out_zero_norm = zn_ff;
   for (genvar g = 0; g < NCOMP; g++) begin : g_out
      assign out_r[g] = signed'(r_ff[g]);
   end

endmodule

// ===== rtl/quaternion_arithmetic_unit.sv =====
// Quaternion arithmetic unit, fixed point (Q2.14 by default).
// Request channel: req_valid/req_ready with req_type (0 conjugate, 1 normalize,
// 2 multiply A*B, 3 rotate vector b by A) and quaternions A and B.
// Result channel: rsp_valid/rsp_ready with rsp_r_w..rsp_r_z, rsp_clipped and
// rsp_zero_norm. Every request gives exactly one result, in request order.
// The pipeline has six front stages of products, sums, the rotate second pass
// and rounding, FRAC_BITS + 1 stages of the normalize search (one result bit
// per stage) and one output stage. Throughput is one transfer per cycle on
// each side while rsp_ready stays high. Every stage holds its
// own valid bit and advances when it is empty or the next stage moves, so a
// stalled receiver backs the pipeline up one stage at a time and req_ready
// drops only when every stage is full; nothing is lost or repeated.
// Reset (synchronous, active high) clears all valid bits; the unit keeps no
// other state.
// Depends on qau_pkg, qau_front, qau_isqrt_stage and qau_out.
module quaternion_arithmetic_unit #(
   parameter int WORD_BITS = 16,
   parameter int FRAC_BITS = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  qau_pkg::op_type              req_type,
   input  logic signed [WORD_BITS-1:0]  req_a_w,
   input  logic signed [WORD_BITS-1:0]  req_a_x,
   input  logic signed [WORD_BITS-1:0]  req_a_y,
   input  logic signed [WORD_BITS-1:0]  req_a_z,
   input  logic signed [WORD_BITS-1:0]  req_b_w,
   input  logic signed [WORD_BITS-1:0]  req_b_x,
   input  logic signed [WORD_BITS-1:0]  req_b_y,
   input  logic signed [WORD_BITS-1:0]  req_b_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [WORD_BITS-1:0]  rsp_r_w,
   output logic signed [WORD_BITS-1:0]  rsp_r_x,
   output logic signed [WORD_BITS-1:0]  rsp_r_y,
   output logic signed [WORD_BITS-1:0]  rsp_r_z,
   output logic                         rsp_clipped,
   output logic                         rsp_zero_norm
);
   import qau_pkg::*;

   localparam int W      = WORD_BITS;
   localparam int F      = FRAC_BITS;
   localparam int XW     = 2 * F + 2 * W + 4;
   localparam int SIDE_W = 4 * W + 8;
   localparam int NST    = F + 1;

   logic signed [W-1:0]    a_vec [NCOMP];
   logic signed [W-1:0]    b_vec [NCOMP];
   logic signed [2*W-1:0]  f_sq  [NCOMP];
   logic signed [W-1:0]    r_vec [NCOMP];

   logic                   ch_valid [NST+1];
   logic                   ch_ready [NST+1];
   logic [SIDE_W-1:0]      ch_side  [NST+1];
   logic [2*W:0]           ch_s     [NST+1];
   logic signed [XW-1:0]   ch_tgt   [NST+1][NCOMP];
   logic signed [XW-1:0]   ch_x     [NST+1][NCOMP];
   logic signed [XW-1:0]   ch_y     [NST+1][NCOMP];
   logic [F:0]             ch_lo    [NST+1][NCOMP];

   assign a_vec[0] = req_a_w;
   assign a_vec[1] = req_a_x;
   assign a_vec[2] = req_a_y;
   assign a_vec[3] = req_a_z;
   assign b_vec[0] = req_b_w;
   assign b_vec[1] = req_b_x;
   assign b_vec[2] = req_b_y;
   assign b_vec[3] = req_b_z;

   qau_front #(
      .WORD_BITS (W),
      .FRAC_BITS (F)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_op     (req_type),
      .in_a      (a_vec),
      .in_b      (b_vec),
      .out_valid (ch_valid[0]),
      .out_ready (ch_ready[0]),
      .out_side  (ch_side[0]),
      .out_s     (ch_s[0]),
      .out_sq    (f_sq)
   );

   for (genvar i = 0; i < NCOMP; i++) begin : g_init
      assign ch_tgt[0][i] = XW'(f_sq[i]) <<< (2 * F + 2);
      assign ch_x[0][i]   = signed'(XW'(ch_s[0]));
      assign ch_y[0][i]   = -signed'(XW'(ch_s[0]));
      assign ch_lo[0][i]  = '0;
   end

   for (genvar g = 0; g < NST; g++) begin : g_search
      qau_isqrt_stage #(
         .WORD_BITS (W),
         .FRAC_BITS (F),
         .BIT       (F - g)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (ch_valid[g]),
         .up_ready (ch_ready[g]),
         .up_side  (ch_side[g]),
         .up_s     (ch_s[g]),
         .up_tgt   (ch_tgt[g]),
         .up_x     (ch_x[g]),
         .up_y     (ch_y[g]),
         .up_lo    (ch_lo[g]),
         .dn_valid (ch_valid[g+1]),
         .dn_ready (ch_ready[g+1]),
         .dn_side  (ch_side[g+1]),
         .dn_s     (ch_s[g+1]),
         .dn_tgt   (ch_tgt[g+1]),
         .dn_x     (ch_x[g+1]),
         .dn_y     (ch_y[g+1]),
         .dn_lo    (ch_lo[g+1])
      );
   end

   qau_out #(
      .WORD_BITS (W),
      .FRAC_BITS (F)
   ) u_out (
      .clock         (clock),
      .reset         (reset),
      .up_valid      (ch_valid[NST]),
      .up_ready      (ch_ready[NST]),
      .up_side       (ch_side[NST]),
      .up_lo         (ch_lo[NST]),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_r         (r_vec),
      .out_clipped   (rsp_clipped),
      .out_zero_norm (rsp_zero_norm)
   );

   assign rsp_r_w = r_vec[0];
   assign rsp_r_x = r_vec[1];
   assign rsp_r_y = r_vec[2];
   assign rsp_r_z = r_vec[3];

endmodule

// ===== bench/quaternion_arithmetic_unit_test.sv =====
// Self-checking bench for the quaternion arithmetic unit: random and corner requests,
// expected results computed in the bench and compared in order on the response channel.
// Depends on qau_pkg and quaternion_arithmetic_unit.
module quaternion_arithmetic_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import qau_pkg::*;

   localparam int WB = 16;
   localparam int FB = 14;
   localparam int LATENCY = FB + 8;
   localparam longint CYCLE_LIMIT = 400000;
   localparam int N_RANDOM = 1150;

   typedef struct packed {
      op_type op;
      logic signed [WB-1:0] aw, ax, ay, az, bw, bx, by, bz;
   } quat_req_t;

   typedef struct packed {
      logic signed [WB-1:0] rw, rx, ry, rz;
      logic clipped, zero_norm;
   } quat_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   op_type req_type = OP_CONJ;
   logic signed [WB-1:0] req_a_w = '0, req_a_x = '0, req_a_y = '0, req_a_z = '0;
   logic signed [WB-1:0] req_b_w = '0, req_b_x = '0, req_b_y = '0, req_b_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [WB-1:0] rsp_r_w, rsp_r_x, rsp_r_y, rsp_r_z;
   logic rsp_clipped, rsp_zero_norm;

   quat_req_t pending_reqs[$];
   quat_rsp_t expected_rsps[$];
   int send_idle_pct = 15;
   int recv_idle_pct = 77;
   bit hold_off = 1'b0;
   int hold_count = 0;
   bit stimulus_done = 1'b0;
   bit req_taken = 1'b0;
   int failures = 0;
   longint cycles = 0;

   quaternion_arithmetic_unit dut (.*);

   always #5 clock = ~clock;

   function automatic longint clamp_word(longint v, inout bit clip);
      longint hi, lo;
      hi = (longint'(1) <<< (WB - 1)) - 1;
      lo = -(longint'(1) <<< (WB - 1));
      if (v > hi) begin
         clip = 1'b1;
         return hi;
      end
      if (v < lo) begin
         clip = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic longint round_down_shift(longint v, int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint unit_component(longint a, longint s);
      logic [127:0] num, target, d, lo, hi, mid;
      num = (a < 0 ? -a : a) << (FB + 1);
      target = num * num;
      lo = 0;
      hi = 128'd1 << FB;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         d = 2 * mid - 1;
         if (d * d * s <= target) lo = mid;
         else hi = mid - 1;
      end
      return a < 0 ? -longint'(lo) : longint'(lo);
   endfunction

   function automatic quat_rsp_t quat_result(quat_req_t q);
      longint a0, a1, a2, a3, b0, b1, b2, b3, s, t1, t2, t3, t4;
      longint r[4];
      bit clip;
      quat_rsp_t o;
      a0 = q.aw; a1 = q.ax; a2 = q.ay; a3 = q.az;
      b0 = q.bw; b1 = q.bx; b2 = q.by; b3 = q.bz;
      clip = 1'b0;
      r = '{0, 0, 0, 0};
      o.zero_norm = 1'b0;
      case (q.op)
         OP_CONJ: begin
            r[0] = clamp_word(a0, clip);
            r[1] = clamp_word(-a1, clip);
            r[2] = clamp_word(-a2, clip);
            r[3] = clamp_word(-a3, clip);
         end
         OP_NORM: begin
            s = a0 * a0 + a1 * a1 + a2 * a2 + a3 * a3;
            if (s == 0) o.zero_norm = 1'b1;
            else begin
               r[0] = clamp_word(unit_component(a0, s), clip);
               r[1] = clamp_word(unit_component(a1, s), clip);
               r[2] = clamp_word(unit_component(a2, s), clip);
               r[3] = clamp_word(unit_component(a3, s), clip);
            end
         end
         OP_MUL: begin
            r[0] = clamp_word(round_down_shift(a0*b0 - a1*b1 - a2*b2 - a3*b3, FB), clip);
            r[1] = clamp_word(round_down_shift(a0*b1 + a1*b0 + a2*b3 - a3*b2, FB), clip);
            r[2] = clamp_word(round_down_shift(a0*b2 - a1*b3 + a2*b0 + a3*b1, FB), clip);
            r[3] = clamp_word(round_down_shift(a0*b3 + a1*b2 - a2*b1 + a3*b0, FB), clip);
         end
         default: begin
            t1 = a0 * b1 - a3 * b2 + a2 * b3;
            t2 = a1 * b2 - a2 * b1 + a0 * b3;
            t3 = a1 * b1 + a2 * b2 + a3 * b3;
            t4 = a3 * b1 + a0 * b2 - a1 * b3;
            r[1] = clamp_word(round_down_shift(a0*t1 + a2*t2 + a1*t3 - a3*t4, 2*FB), clip);
            r[2] = clamp_word(round_down_shift(a0*t4 - a1*t2 + a2*t3 + a3*t1, 2*FB), clip);
            r[3] = clamp_word(round_down_shift(a0*t2 + a1*t4 - a2*t1 + a3*t3, 2*FB), clip);
         end
      endcase
      o.rw = r[0][WB-1:0];
      o.rx = r[1][WB-1:0];
      o.ry = r[2][WB-1:0];
      o.rz = r[3][WB-1:0];
      o.clipped = clip;
      return o;
   endfunction

   function automatic logic signed [WB-1:0] random_comp();
      case ($urandom_range(0, 5))
         0: return WB'($urandom);
         1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         2: return WB'(int'($urandom_range(0, 6)) - 3);
         default: return WB'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic quat_req_t make_req(op_type op, int a0, int a1, int a2, int a3,
                                          int b0, int b1, int b2, int b3);
      quat_req_t q;
      q.op = op;
      q.aw = WB'(a0); q.ax = WB'(a1); q.ay = WB'(a2); q.az = WB'(a3);
      q.bw = WB'(b0); q.bx = WB'(b1); q.by = WB'(b2); q.bz = WB'(b3);
      return q;
   endfunction

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               quat_req_t q;
               q = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_type <= q.op;
               req_a_w <= q.aw; req_a_x <= q.ax; req_a_y <= q.ay; req_a_z <= q.az;
               req_b_w <= q.bw; req_b_x <= q.bx; req_b_y <= q.by; req_b_z <= q.bz;
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (hold_off) begin
            rsp_ready <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count >= 200) hold_off <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready)
         expected_rsps.push_back(quat_result({req_type, req_a_w, req_a_x, req_a_y, req_a_z,
                                              req_b_w, req_b_x, req_b_y, req_b_z}));
      if (!reset && rsp_valid && rsp_ready) begin
         quat_rsp_t got, want;
         got = {rsp_r_w, rsp_r_x, rsp_r_y, rsp_r_z, rsp_clipped, rsp_zero_norm};
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected transfer %h", $time, got);
            failures++;
         end else begin
            want = expected_rsps.pop_front();
            if (got.rw !== want.rw || got.rx !== want.rx || got.ry !== want.ry ||
                got.rz !== want.rz || got.clipped !== want.clipped ||
                got.zero_norm !== want.zero_norm) begin
               $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d clip=%b zn=%b",
                        $time, want.rw, want.rx, want.ry, want.rz, want.clipped,
                        want.zero_norm);
               $display("%0t: actual w=%0d x=%0d y=%0d z=%0d clip=%b zn=%b",
                        $time, got.rw, got.rx, got.ry, got.rz, got.clipped, got.zero_norm);
               failures++;
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      op_type op;
      pending_reqs.push_back(make_req(OP_CONJ, 16384, -32768, 32767, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_CONJ, -32768, 1, -1, -32768, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_NORM, 0, 0, 0, 0, 5, 5, 5, 5));
      pending_reqs.push_back(make_req(OP_NORM, 1, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_NORM, -32768, -32768, -32768, -32768, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_NORM, 32767, 32767, 32767, 32767, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_NORM, 0, -1, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_NORM, 3, 4, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_MUL, 16384, 0, 0, 0, 1234, -5, 32767, -32768));
      pending_reqs.push_back(make_req(OP_MUL, -32768, -32768, -32768, -32768,
                                      -32768, -32768, -32768, -32768));
      pending_reqs.push_back(make_req(OP_MUL, 32767, 32767, 32767, 32767,
                                      32767, -32768, 32767, -32768));
      pending_reqs.push_back(make_req(OP_MUL, 1, 0, 0, 0, 8192, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_MUL, -1, 0, 0, 0, 8192, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_ROT, 11585, 0, 0, 11585, 7, 100, -100, 5));
      pending_reqs.push_back(make_req(OP_ROT, -32768, -32768, -32768, -32768,
                                      0, 32767, -32768, 32767));
      pending_reqs.push_back(make_req(OP_ROT, 16384, 0, 0, 0, 0, -32768, 32767, 1));
      for (int i = 0; i < N_RANDOM; i++) begin
         op = op_type'($urandom_range(0, 3));
         pending_reqs.push_back(make_req(op, random_comp(), random_comp(), random_comp(),
                                         random_comp(), random_comp(), random_comp(),
                                         random_comp(), random_comp()));
      end
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      wait (pending_reqs.size() < 1000);
      @(negedge clock) hold_off <= 1'b1;
      wait (pending_reqs.size() < 800);
      send_idle_pct = 77;
      recv_idle_pct = 15;
      wait (pending_reqs.size() < 400);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_rsps.size() == 0);
      repeat (LATENCY * 2) @(posedge clock);
      if (failures == 0 && expected_rsps.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/qau_pkg.sv
rtl/qau_front.sv
rtl/qau_isqrt_stage.sv
rtl/qau_out.sv
rtl/quaternion_arithmetic_unit.sv
bench/quaternion_arithmetic_unit_test.sv
